// ===== src/lifp_pkg.sv =====
// ----------------------------------------------------------------------------
// lifp_pkg
// Shared types, constants and helpers for the paired LIF neuron update.
// ----------------------------------------------------------------------------
package lifp_pkg;

  localparam int NEURON_COUNT      = 1024;
  localparam int ADDR_W            = $clog2(NEURON_COUNT);
  localparam int IDX_W             = 10;
  localparam int SELF_EXCITE_SCALE = 65536;

  localparam int FRAC    = 16;
  localparam int MUL_A_W = 18;
  localparam int DRV_W   = 36;
  localparam int PROD_W  = MUL_A_W + DRV_W;
  localparam int Q_W     = PROD_W - FRAC;
  localparam int ACC_W   = 40;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXC_THRESHOLD  = 3'd0,
    CFG_INH_THRESHOLD  = 3'd1,
    CFG_EXC_LEAK_RATE  = 3'd2,
    CFG_INH_LEAK_RATE  = 3'd3,
    CFG_EXC_NOISE_FREQ = 3'd4,
    CFG_INH_NOISE_FREQ = 3'd5,
    CFG_INH_NOISE_AMP  = 3'd6,
    CFG_INHIBIT_GAIN   = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] exc_threshold;
    logic signed [31:0] inh_threshold;
    logic [16:0]        exc_leak_rate;
    logic [16:0]        inh_leak_rate;
    logic [16:0]        exc_noise_freq;
    logic [16:0]        inh_noise_freq;
    logic [30:0]        inh_noise_amp;
    logic [30:0]        inhibit_gain;
  } cfg_t;

  typedef struct packed {
    logic               fired;
    logic signed [31:0] inh;
    logic signed [31:0] exc;
  } store_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_NMUL,
    ST_NUPD,
    ST_HDRV,
    ST_HMUL,
    ST_HSAT,
    ST_HFIRE,
    ST_VDRV,
    ST_VMUL,
    ST_VSAT,
    ST_VFIRE
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    if (x > $signed({{(ACC_W-32){1'b0}}, 32'h7fff_ffff})) begin
      return 32'sh7fff_ffff;
    end else if (x < $signed({{(ACC_W-32){1'b1}}, 32'h8000_0000})) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  // strict "above threshold" test without wrap
  function automatic logic above(input logic signed [31:0] p, input logic signed [31:0] thr);
    logic signed [32:0] diff;
    diff = {p[31], p} - {thr[31], thr};
    return !diff[32] && (diff != 33'sd0);
  endfunction

endpackage

// ===== src/lifp_cfg.sv =====
// ----------------------------------------------------------------------------
// lifp_cfg
// Configuration register file.
// ----------------------------------------------------------------------------
module lifp_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                we,
  input  logic [lifp_pkg::CFG_IDX_W-1:0]      index,
  input  logic [31:0]                         data,
  output lifp_pkg::cfg_t                      cfg
);
  import lifp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.exc_threshold  <= 32'sd32768;
      cfg.inh_threshold  <= 32'sd32768;
      cfg.exc_leak_rate  <= 17'd6554;
      cfg.inh_leak_rate  <= 17'd6554;
      cfg.exc_noise_freq <= 17'd0;
      cfg.inh_noise_freq <= 17'd0;
      cfg.inh_noise_amp  <= 31'd0;
      cfg.inhibit_gain   <= 31'd65536;
    end else if (we) begin
      case (cfg_idx_t'(index))
        CFG_EXC_THRESHOLD:  cfg.exc_threshold  <= data;
        CFG_INH_THRESHOLD:  cfg.inh_threshold  <= data;
        CFG_EXC_LEAK_RATE:  cfg.exc_leak_rate  <= data[16:0];
        CFG_INH_LEAK_RATE:  cfg.inh_leak_rate  <= data[16:0];
        CFG_EXC_NOISE_FREQ: cfg.exc_noise_freq <= data[16:0];
        CFG_INH_NOISE_FREQ: cfg.inh_noise_freq <= data[16:0];
        CFG_INH_NOISE_AMP:  cfg.inh_noise_amp  <= data[30:0];
        CFG_INHIBIT_GAIN:   cfg.inhibit_gain   <= data[30:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/lifp_mul.sv =====
// ----------------------------------------------------------------------------
// lifp_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module lifp_mul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [lifp_pkg::MUL_A_W-1:0] a,
  input  logic signed [lifp_pkg::DRV_W-1:0]   b,
  output logic signed [lifp_pkg::PROD_W-1:0]  prod
);
  import lifp_pkg::*;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

// ===== src/lifp_store.sv =====
// ----------------------------------------------------------------------------
// lifp_store
// Per-neuron state memory: potentials and last fire flag.
// ----------------------------------------------------------------------------
module lifp_store (
  input  logic                            clk,
  input  logic                            we,
  input  logic [lifp_pkg::ADDR_W-1:0]     waddr,
  input  lifp_pkg::store_word_t           wdata,
  input  logic                            re,
  input  logic [lifp_pkg::ADDR_W-1:0]     raddr,
  output lifp_pkg::store_word_t           rdata
);
  import lifp_pkg::*;

  store_word_t mem [NEURON_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/lif_neuron_pair_update.sv =====
// ----------------------------------------------------------------------------
// lif_neuron_pair_update: a new request is taken only after the previous one has
// been delivered; each update makes three passes through the one multiplier.
// Sync reset: clears all 1024 entries of the neuron store, not ready until done.
// ----------------------------------------------------------------------------
module lif_neuron_pair_update (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [lifp_pkg::IDX_W-1:0]          neuron_index,
  input  logic signed [31:0]                  partial_potential,
  input  logic signed [31:0]                  image_value,
  input  logic [15:0]                         inh_gate_draw,
  input  logic [15:0]                         inh_amp_draw,
  input  logic [15:0]                         exc_gate_draw,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  exc_potential,
  output logic                                exc_fired,
  output logic signed [31:0]                  inh_potential,
  output logic                                inh_fired,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lifp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_data
);
  import lifp_pkg::*;

  localparam logic signed [DRV_W-1:0] SELF_EXC = DRV_W'(SELF_EXCITE_SCALE);

  state_t state, state_next;
  cfg_t   cfg;

  logic [ADDR_W-1:0] clr_cnt;
  logic              accept;
  logic              deliver;
  logic              mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [DRV_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [Q_W-1:0]     q;

  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  store_word_t               mem_wdata;
  store_word_t               cur;

  logic [ADDR_W-1:0]         idx;
  logic signed [31:0]        phi;
  logic signed [31:0]        img;
  logic                      inh_pass;
  logic                      exc_pass;
  logic signed [MUL_A_W-1:0] term;
  logic signed [31:0]        noise;
  logic signed [DRV_W-1:0]   pv;
  logic signed [DRV_W-1:0]   drive;
  logic signed [31:0]        acc;
  logic signed [31:0]        h_new;
  logic                      hf;
  logic                      vf;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign q         = prod[PROD_W-1:FRAC];
  assign vf        = above(acc, cfg.exc_threshold);

  lifp_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_valid && cfg_ready),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  lifp_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  lifp_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (neuron_index[ADDR_W-1:0]),
    .rdata (cur)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == ADDR_W'(NEURON_COUNT - 1)) state_next = ST_IDLE;
      ST_IDLE:  if (in_valid) state_next = ST_NMUL;
      ST_NMUL:  state_next = ST_NUPD;
      ST_NUPD:  state_next = ST_HDRV;
      ST_HDRV:  state_next = ST_HMUL;
      ST_HMUL:  state_next = ST_HSAT;
      ST_HSAT:  state_next = ST_HFIRE;
      ST_HFIRE: state_next = ST_VDRV;
      ST_VDRV:  state_next = ST_VMUL;
      ST_VMUL:  state_next = ST_VSAT;
      ST_VSAT:  state_next = ST_VFIRE;
      ST_VFIRE: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    deliver   = 1'b0;
    mul_en    = 1'b0;
    mul_a     = term;
    mul_b     = DRV_W'($signed({1'b0, cfg.inh_noise_amp}));
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = '{fired: vf, inh: h_new, exc: (vf ? 32'sd0 : acc)};
    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      ST_IDLE:  in_ready = 1'b1;
      ST_NMUL:  mul_en = 1'b1;
      ST_HMUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, cfg.inh_leak_rate});
        mul_b  = drive;
      end
      ST_VMUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, cfg.exc_leak_rate});
        mul_b  = drive;
      end
      ST_VFIRE: begin
        deliver = !out_valid || out_ready;
        mem_we  = deliver;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (state == ST_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // carried noise value
  always_ff @(posedge clk) begin
    if (rst) begin
      noise <= '0;
    end else if (state == ST_NUPD && inh_pass) begin
      noise <= q[31:0];
    end else if (state == ST_HFIRE && exc_pass) begin
      noise <= (img > 32'sd0) ? img : 32'sd0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          idx      <= neuron_index[ADDR_W-1:0];
          phi      <= partial_potential;
          img      <= image_value;
          inh_pass <= {1'b0, inh_gate_draw} < cfg.inh_noise_freq;
          exc_pass <= {1'b0, exc_gate_draw} < cfg.exc_noise_freq;
          term     <= $signed({1'b0, inh_amp_draw, 1'b0}) - 18'sd65536;
        end
      end
      ST_NUPD: pv <= DRV_W'(phi) - (cur.fired ? SELF_EXC : 36'sd0) - DRV_W'(cur.exc);
      ST_HDRV: drive <= DRV_W'(noise) + DRV_W'(phi) - DRV_W'(cur.inh);
      ST_HSAT: acc <= sat32(ACC_W'(cur.inh) + ACC_W'(q));
      ST_HFIRE: begin
        hf    <= above(acc, cfg.inh_threshold);
        h_new <= above(acc, cfg.inh_threshold) ? 32'sd0 : acc;
      end
      ST_VDRV: drive <= DRV_W'(noise) + pv
                        - (hf ? DRV_W'($signed({1'b0, cfg.inhibit_gain})) : 36'sd0);
      ST_VSAT: acc <= sat32(ACC_W'(cur.exc) + ACC_W'(q));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (deliver) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      exc_potential <= vf ? 32'sd0 : acc;
      exc_fired     <= vf;
      inh_potential <= h_new;
      inh_fired     <= hf;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_NMUL)
    else $error("accepted request did not start the sequence");

  a_result_from_fire: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_VFIRE)
    else $error("result appeared outside the final step");

  a_exc_reset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && exc_fired) |-> exc_potential == 32'sd0)
    else $error("excitatory cell fired without reset");

  a_inh_reset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && inh_fired) |-> inh_potential == 32'sd0)
    else $error("inhibitory cell fired without reset");

endmodule

// ===== sim/tb_lif_neuron_pair_update.sv =====
// ----------------------------------------------------------------------------
// tb_lif_neuron_pair_update
// Self-checking bench for the paired LIF neuron update: a directed table of
// corner requests and register writes, then random phases under tame and extreme
// register settings. Results are checked against a local model or known values.
// ----------------------------------------------------------------------------
module tb_lif_neuron_pair_update;
  import lifp_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE          = 12;
  localparam int HOLD_CYCLES     = 400;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 300;

  typedef struct packed {
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] phi;
    logic signed [31:0] img;
    logic [15:0]        inh_gate;
    logic [15:0]        amp_draw;
    logic [15:0]        exc_gate;
  } neuron_req_t;

  typedef struct packed {
    logic signed [31:0] exc_v;
    logic               exc_f;
    logic signed [31:0] inh_v;
    logic               inh_f;
  } neuron_out_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_KNOWN} row_kind_t;

  // config rows carry their write data in phi
  typedef struct packed {
    row_kind_t          kind;
    logic [2:0]         reg_sel;
    logic [IDX_W-1:0]   idx;
    logic signed [31:0] phi;
    logic signed [31:0] img;
    logic [15:0]        inh_gate;
    logic [15:0]        amp_draw;
    logic [15:0]        exc_gate;
    neuron_out_t        exp;
  } directed_row_t;

  localparam int PLAN_LEN = 34;

  directed_row_t plan [PLAN_LEN] = '{
    '{kind: ROW_KNOWN, default: 0},
    '{kind: ROW_ITEM, idx: 10'd1023, phi: 32'h7fff_ffff, img: 32'h7fff_ffff,
      inh_gate: 16'hffff, amp_draw: 16'hffff, exc_gate: 16'hffff, default: 0},
    '{kind: ROW_ITEM, idx: 10'd1023, default: 0},
    '{kind: ROW_ITEM, idx: 10'd1023, phi: 32'h8000_0000, img: 32'h8000_0000, default: 0},
    '{kind: ROW_CFG, reg_sel: CFG_EXC_LEAK_RATE, phi: 32'h0001_ffff, default: 0},
    '{kind: ROW_CFG, reg_sel: CFG_INH_LEAK_RATE, phi: 32'h0001_ffff, default: 0},
    '{kind: ROW_KNOWN, idx: 10'd5, phi: 32'h7fff_ffff,
      exp: '{32'h0, 1'b1, 32'h0, 1'b1}, default: 0},
    '{kind: ROW_KNOWN, idx: 10'd6, phi: 32'h8000_0000,
      exp: '{32'h8000_0000, 1'b0, 32'h8000_0000, 1'b0}, default: 0},
    '{kind: ROW_ITEM, idx: 10'd5, default: 0},
    '{kind: ROW_CFG, reg_sel: CFG_EXC_THRESHOLD, phi: 32'h8000_0000, default: 0},
    '{kind: ROW_CFG, reg_sel: CFG_INH_THRESHOLD, phi: 32'h8000_0000, default: 0},
    '{kind: ROW_CFG, reg_sel: CFG_EXC_LEAK_RATE, phi: 32'h0, default: 0},
    '{kind: ROW_CFG, reg_sel: CFG_INH_LEAK_RATE, phi: 32'h0, default: 0},
    '{kind: ROW_KNOWN, idx: 10'd7, phi: 32'h1234_5678, img: 32'h8765_4321,
      exp: '{32'h0, 1'b1, 32'h0, 1'b1}, default: 0},
    '{kind: ROW_CFG, reg_sel: CFG_EXC_THRESHOLD, phi: 32'h7fff_ffff, default: 0},
    '{kind: ROW_CFG, reg_sel: CFG_INH_THRESHOLD, phi: 32'h7fff_ffff, default: 0},
    '{kind: ROW_CFG, reg_sel: CFG_EXC_LEAK_RATE, phi: 32'h0001_0000, default: 0},
    '{kind: ROW_CFG, reg_sel: CFG_INH_LEAK_RATE, phi: 32'h0001_0000, default: 0},
    '{kind: ROW_KNOWN, idx: 10'd8, phi: 32'h7fff_ffff,
      exp: '{32'h7fff_ffff, 1'b0, 32'h7fff_ffff, 1'b0}, default: 0},
    '{kind: ROW_CFG, reg_sel: CFG_INH_NOISE_FREQ, phi: 32'h0001_0000, default: 0},
    '{kind: ROW_CFG, reg_sel: CFG_INH_NOISE_AMP, phi: 32'hffff_ffff, default: 0},
    '{kind: ROW_KNOWN, idx: 10'd9, inh_gate: 16'hffff,
      exp: '{32'h8000_0001, 1'b0, 32'h8000_0001, 1'b0}, default: 0},
    '{kind: ROW_ITEM, idx: 10'd10, img: 32'h0005_0000, amp_draw: 16'hffff, default: 0},
    '{kind: ROW_CFG, reg_sel: CFG_INH_NOISE_FREQ, phi: 32'h0, default: 0},
    '{kind: ROW_CFG, reg_sel: CFG_EXC_NOISE_FREQ, phi: 32'h0001_ffff, default: 0},
    '{kind: ROW_CFG, reg_sel: CFG_INH_THRESHOLD, phi: 32'h8000_0000, default: 0},
    '{kind: ROW_CFG, reg_sel: CFG_INHIBIT_GAIN, phi: 32'hffff_ffff, default: 0},
    '{kind: ROW_ITEM, idx: 10'd11, img: 32'h8000_0000, exc_gate: 16'hffff, default: 0},
    '{kind: ROW_ITEM, idx: 10'd12, phi: 32'h0003_0000, img: 32'h7fff_ffff,
      exc_gate: 16'hffff, default: 0},
    '{kind: ROW_CFG, reg_sel: CFG_EXC_NOISE_FREQ, phi: 32'h0000_ffff, default: 0},
    '{kind: ROW_ITEM, idx: 10'd12, img: 32'h0004_0000, exc_gate: 16'hffff, default: 0},
    '{kind: ROW_ITEM, idx: 10'd13, img: 32'h0004_0000, exc_gate: 16'hfffe, default: 0},
    '{kind: ROW_ITEM, idx: 10'h2aa, phi: 32'haaaa_aaaa, img: 32'h5555_5555,
      inh_gate: 16'haaaa, amp_draw: 16'h5555, exc_gate: 16'haaaa, default: 0},
    '{kind: ROW_ITEM, idx: 10'h155, phi: 32'h5555_5555, img: 32'haaaa_aaaa,
      inh_gate: 16'h5555, amp_draw: 16'haaaa, exc_gate: 16'h5555, default: 0}
  };

  logic               clk;
  logic               rst               = 1'b1;
  logic               in_valid          = 1'b0;
  logic               in_ready;
  logic [IDX_W-1:0]   neuron_index      = '0;
  logic signed [31:0] partial_potential = '0;
  logic signed [31:0] image_value       = '0;
  logic [15:0]        inh_gate_draw     = '0;
  logic [15:0]        inh_amp_draw      = '0;
  logic [15:0]        exc_gate_draw     = '0;
  logic               out_valid;
  logic               out_ready         = 1'b0;
  logic signed [31:0] exc_potential;
  logic               exc_fired;
  logic signed [31:0] inh_potential;
  logic               inh_fired;
  logic               cfg_valid         = 1'b0;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index       = '0;
  logic [31:0]        cfg_data          = '0;

  // neuron model state
  cfg_t               shadow_cfg;
  logic signed [31:0] exc_level [NEURON_COUNT];
  logic signed [31:0] inh_level [NEURON_COUNT];
  logic               exc_spiked [NEURON_COUNT];
  longint             noise_carry;

  neuron_out_t        awaited_updates [$];
  int                 mismatches  = 0;
  int                 cycle_count = 0;
  bit                 quiet        = 1'b0;
  bit                 hold_request = 1'b0;
  int                 hold_left    = 0;

  lif_neuron_pair_update u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** lif_neuron_pair_update: FAILED **");
      $finish;
    end
  end

  function automatic longint q16_mul(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic longint clip_q16(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic void apply_reg(input cfg_idx_t sel, input logic [31:0] data);
    case (sel)
      CFG_EXC_THRESHOLD:  shadow_cfg.exc_threshold  = data;
      CFG_INH_THRESHOLD:  shadow_cfg.inh_threshold  = data;
      CFG_EXC_LEAK_RATE:  shadow_cfg.exc_leak_rate  = data[16:0];
      CFG_INH_LEAK_RATE:  shadow_cfg.inh_leak_rate  = data[16:0];
      CFG_EXC_NOISE_FREQ: shadow_cfg.exc_noise_freq = data[16:0];
      CFG_INH_NOISE_FREQ: shadow_cfg.inh_noise_freq = data[16:0];
      CFG_INH_NOISE_AMP:  shadow_cfg.inh_noise_amp  = data[30:0];
      CFG_INHIBIT_GAIN:   shadow_cfg.inhibit_gain   = data[30:0];
      default: ;
    endcase
  endfunction

  function automatic neuron_out_t advance_neuron(input neuron_req_t req);
    int          n;
    longint      phi, img, h, v, drive;
    logic        hf, vf;
    neuron_out_t res;
    n   = int'(req.idx) % NEURON_COUNT;
    phi = longint'($signed(req.phi));
    img = longint'($signed(req.img));

    if (req.inh_gate < shadow_cfg.inh_noise_freq) begin
      noise_carry = q16_mul(longint'(shadow_cfg.inh_noise_amp),
                            2 * longint'(req.amp_draw) - 65536);
    end
    h     = longint'(inh_level[n]);
    drive = noise_carry + phi - h;
    h     = clip_q16(h + q16_mul(longint'(shadow_cfg.inh_leak_rate), drive));
    hf    = (h - longint'($signed(shadow_cfg.inh_threshold))) > 0;
    if (hf) h = 0;
    inh_level[n] = h[31:0];

    if (req.exc_gate < shadow_cfg.exc_noise_freq) begin
      noise_carry = (img > 0) ? img : 0;
    end
    if (exc_spiked[n]) phi -= longint'(SELF_EXCITE_SCALE);

    v     = longint'(exc_level[n]);
    drive = noise_carry + phi - v - (hf ? longint'(shadow_cfg.inhibit_gain) : 0);
    v     = clip_q16(v + q16_mul(longint'(shadow_cfg.exc_leak_rate), drive));
    vf    = (v - longint'($signed(shadow_cfg.exc_threshold))) > 0;
    if (vf) v = 0;
    exc_level[n]  = v[31:0];
    exc_spiked[n] = vf;

    res = '{v[31:0], vf, h[31:0], hf};
    return res;
  endfunction

  function automatic logic [31:0] pick_potential();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return 32'($urandom_range(0, 32'h0006_0000)) - 32'h0003_0000;
    if (roll < 80) return roll[0] ? 32'h7fff_ffff : 32'h8000_0000;
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_draw();
    int unsigned roll;
    roll = $urandom_range(19);
    if (roll == 0) return 16'h0000;
    if (roll == 1) return 16'hffff;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic neuron_req_t random_request();
    neuron_req_t req;
    // mostly a small pool of neurons so stored state gets revisited
    if ($urandom_range(99) < 80) req.idx = IDX_W'($urandom_range(0, 15));
    else req.idx = IDX_W'($urandom_range(0, 1023));
    req.phi      = pick_potential();
    req.img      = pick_potential();
    req.inh_gate = pick_draw();
    req.amp_draw = pick_draw();
    req.exc_gate = pick_draw();
    return req;
  endfunction

  function automatic logic [31:0] corner_pick(input logic [31:0] lo, input logic [31:0] hi);
    case ($urandom_range(2))
      0: return lo;
      1: return hi;
      default: return $urandom;
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0s mismatch: expected %h, got %h", name, want, got);
      end
    end
  endtask

  // result side: random backpressure plus one long hold
  always @(posedge clk) begin
    neuron_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_updates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: exc %h inh %h",
                                       exc_potential, inh_potential);
      end else begin
        want = awaited_updates.pop_front();
        compare_field("exc_potential", want.exc_v, exc_potential);
        compare_field("exc_fired", 32'(want.exc_f), 32'(exc_fired));
        compare_field("inh_potential", want.inh_v, inh_potential);
        compare_field("inh_fired", 32'(want.inh_f), 32'(inh_fired));
      end
    end
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 6);
    end
  end

  task automatic send_request(input neuron_req_t req, input bit known,
                              input neuron_out_t known_res);
    neuron_out_t predicted;
    while (!quiet && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    neuron_index      <= req.idx;
    partial_potential <= req.phi;
    image_value       <= req.img;
    inh_gate_draw     <= req.inh_gate;
    inh_amp_draw      <= req.amp_draw;
    exc_gate_draw     <= req.exc_gate;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = advance_neuron(req);
    awaited_updates.push_back(known ? known_res : predicted);
  endtask

  task automatic write_reg(input cfg_idx_t sel, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(sel, data);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_updates.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic program_phase(input bit wild);
    logic [31:0] val [8];
    settle();
    if (wild) begin
      val[CFG_EXC_THRESHOLD]  = corner_pick(32'h8000_0000, 32'h7fff_ffff);
      val[CFG_INH_THRESHOLD]  = corner_pick(32'h8000_0000, 32'h7fff_ffff);
      val[CFG_EXC_LEAK_RATE]  = corner_pick(32'h0, 32'h0001_ffff);
      val[CFG_INH_LEAK_RATE]  = corner_pick(32'h0, 32'h0001_ffff);
      val[CFG_EXC_NOISE_FREQ] = corner_pick(32'h0, 32'h0001_0000);
      val[CFG_INH_NOISE_FREQ] = corner_pick(32'h0, 32'h0001_ffff);
      val[CFG_INH_NOISE_AMP]  = corner_pick(32'h0, 32'h7fff_ffff);
      val[CFG_INHIBIT_GAIN]   = corner_pick(32'h0, 32'hffff_ffff);
    end else begin
      val[CFG_EXC_THRESHOLD]  = $urandom_range(32'h2000, 32'h3_0000);
      val[CFG_INH_THRESHOLD]  = $urandom_range(32'h2000, 32'h3_0000);
      val[CFG_EXC_LEAK_RATE]  = $urandom_range(32'h0800, 32'h1_0000);
      val[CFG_INH_LEAK_RATE]  = $urandom_range(32'h0800, 32'h1_0000);
      val[CFG_EXC_NOISE_FREQ] = $urandom_range(0, 32'h1_0000);
      val[CFG_INH_NOISE_FREQ] = $urandom_range(0, 32'h1_0000);
      val[CFG_INH_NOISE_AMP]  = $urandom_range(0, 32'h4_0000);
      val[CFG_INHIBIT_GAIN]   = $urandom_range(0, 32'h3_0000);
    end
    for (int k = 0; k < 8; k++) write_reg(cfg_idx_t'(k), val[k]);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    neuron_req_t req;
    shadow_cfg = '{exc_threshold: 32'sd32768, inh_threshold: 32'sd32768,
                   exc_leak_rate: 17'd6554, inh_leak_rate: 17'd6554,
                   exc_noise_freq: 17'd0, inh_noise_freq: 17'd0,
                   inh_noise_amp: 31'd0, inhibit_gain: 31'd65536};
    for (int i = 0; i < NEURON_COUNT; i++) begin
      exc_level[i]  = '0;
      inh_level[i]  = '0;
      exc_spiked[i] = 1'b0;
    end
    noise_carry = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        if (i == 0 || plan[i-1].kind != ROW_CFG) settle();
        write_reg(cfg_idx_t'(plan[i].reg_sel), plan[i].phi);
        if (i == PLAN_LEN - 1 || plan[i+1].kind != ROW_CFG) cfg_valid <= 1'b0;
      end else begin
        req = '{plan[i].idx, plan[i].phi, plan[i].img,
                plan[i].inh_gate, plan[i].amp_draw, plan[i].exc_gate};
        send_request(req, plan[i].kind == ROW_KNOWN, plan[i].exp);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      program_phase(p == 1 || p == 3 || p == 4);
      quiet = (p == 3);
      if (p == 2) hold_request = 1'b1;
      repeat (ITEMS_PER_PHASE) send_request(random_request(), 1'b0, '0);
    end
    quiet = 1'b0;

    settle();
    if (mismatches == 0 && awaited_updates.size() == 0) begin
      $display("** lif_neuron_pair_update: PASSED **");
    end else begin
      $display("** lif_neuron_pair_update: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/lifp_pkg.sv
src/lifp_cfg.sv
src/lifp_mul.sv
src/lifp_store.sv
src/lif_neuron_pair_update.sv
sim/tb_lif_neuron_pair_update.sv
